// ===== hw/rtl/lpfl_pkg.sv =====
package lpfl_pkg;

  // Table geometry
  localparam int unsigned FRAMES    = 8;
  localparam int unsigned PAGE_BITS = 16;
  localparam int unsigned AGE_BITS  = 16;
  localparam int unsigned IDX_W     = $clog2(FRAMES);

  // Stream field widths
  localparam int unsigned PAGE_FIELD_W  = 16;
  localparam int unsigned FRAME_FIELD_W = 3;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned IN_TDATA_W    = ((PAGE_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W  = 1 + FRAME_FIELD_W + 2 * TOTAL_W;
  localparam int unsigned OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [AGE_BITS-1:0]  age_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [TOTAL_W-1:0]   total_t;

  // Outcome of one table access
  typedef struct packed {
    logic hit;
    idx_t frame;
  } lpfl_lookup_t;

endpackage

// ===== hw/rtl/lpfl_victim.sv =====
module lpfl_victim
  import lpfl_pkg::*;
(
  input  age_t [FRAMES-1:0] ages_i,
  output idx_t              victim_o
);

  localparam int unsigned LEAVES = 1 << IDX_W;
  localparam int unsigned NODES  = 2 * LEAVES - 1;

  age_t node_age [NODES];
  idx_t node_idx [NODES];

  // Oldest-age tree; the left (lower) side wins ties, padding leaves sit at age zero
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      node_age[LEAVES - 1 + i] = (i < FRAMES) ? ages_i[i] : '0;
      node_idx[LEAVES - 1 + i] = IDX_W'(i);
    end
    for (int k = LEAVES - 2; k >= 0; k--) begin
      if (node_age[2 * k + 2] > node_age[2 * k + 1]) begin
        node_age[k] = node_age[2 * k + 2];
        node_idx[k] = node_idx[2 * k + 2];
      end else begin
        node_age[k] = node_age[2 * k + 1];
        node_idx[k] = node_idx[2 * k + 1];
      end
    end
  end

  assign victim_o = node_idx[0];

endmodule

// ===== hw/rtl/lpfl_table.sv =====
module lpfl_table
  import lpfl_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         lookup_en_i,
  input  page_t        page_i,
  output lpfl_lookup_t lookup_o
);

  page_t             tag_q [FRAMES];
  logic [FRAMES-1:0] valid_q;
  age_t [FRAMES-1:0] age_q;

  logic match;
  idx_t match_idx;
  logic any_free;
  idx_t free_idx;
  idx_t victim_idx;
  idx_t sel_idx;

  lpfl_victim u_victim (
    .ages_i   (age_q),
    .victim_o (victim_idx)
  );

  // Lowest matching valid frame and lowest empty frame
  always_comb begin
    match     = 1'b0;
    match_idx = '0;
    any_free  = 1'b0;
    free_idx  = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (valid_q[i] && (tag_q[i] == page_i)) begin
        match     = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        any_free = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (match) begin
      sel_idx = match_idx;
    end else if (any_free) begin
      sel_idx = free_idx;
    end else begin
      sel_idx = victim_idx;
    end
  end

  assign lookup_o.hit   = match;
  assign lookup_o.frame = sel_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      age_q   <= '0;
    end else if (lookup_en_i) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (IDX_W'(i) == sel_idx) begin
          age_q[i]   <= '0;
          valid_q[i] <= 1'b1;
        end else if (age_q[i] != '1) begin
          age_q[i] <= age_q[i] + 1'b1;
        end
      end
    end
  end

  // Install the page on a miss
  always_ff @(posedge clk_i) begin
    if (lookup_en_i && !match) begin
      tag_q[sel_idx] <= page_i;
    end
  end

endmodule

// ===== hw/rtl/lru_page_frame_lookup_unit.sv =====
// LRU page frame lookup: a fully associative table of FRAMES frames, each with a
// page tag, valid bit and saturating age counter. Every input beat is one page
// access and gives exactly one output beat reporting hit, the frame now holding
// the page, and wrapping running hit/miss totals. A miss fills the lowest empty
// frame, else evicts the oldest frame (lowest index on ties). One beat per clock
// is sustained while the output is not stalled; each access passes the input
// register, then the tag compare, oldest-age tree and table update that load
// the output register. The table comes out of reset empty with no clearing pass.
module lru_page_frame_lookup_unit
  import lpfl_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [15:0] page_number
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // [0] hit, [3:1] frame,
                                                   // [35:4] hit_total,
                                                   // [67:36] miss_total, rest zero
);

  logic         in_valid_q;
  page_t        page_q;
  logic         advance;
  logic         lookup_en;
  lpfl_lookup_t lookup;

  total_t hits_q, hits_d;
  total_t misses_q, misses_d;

  logic                     out_valid_q;
  logic                     out_hit_q;
  logic [FRAME_FIELD_W-1:0] out_frame_q;
  total_t                   out_hits_q;
  total_t                   out_misses_q;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign lookup_en       = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      page_q <= PAGE_BITS'(s_axis_tdata_i[PAGE_FIELD_W-1:0]);
    end
  end

  lpfl_table u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lookup_en_i (lookup_en),
    .page_i      (page_q),
    .lookup_o    (lookup)
  );

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (lookup.hit) begin
      hits_d = hits_q + 1'b1;
    end else begin
      misses_d = misses_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (lookup_en) begin
        hits_q   <= hits_d;
        misses_q <= misses_d;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i) begin
    if (lookup_en) begin
      out_hit_q    <= lookup.hit;
      out_frame_q  <= FRAME_FIELD_W'(lookup.frame);
      out_hits_q   <= hits_d;
      out_misses_q <= misses_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_misses_q, out_hits_q, out_frame_q, out_hit_q};

endmodule

// ===== hw/rtl/lpfl_checker.sv =====
module lpfl_checker
  import lpfl_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic   out_beat;
  logic   beat_hit;
  total_t beat_hits;
  total_t beat_misses;
  total_t last_hits_q;
  total_t last_misses_q;
  logic   in_beat;
  logic   in_beat_q;

  assign out_beat    = m_axis_tvalid_o && m_axis_tready_i;
  assign in_beat     = s_axis_tvalid_i && s_axis_tready_o;
  assign beat_hit    = m_axis_tdata_o[0];
  assign beat_hits   = m_axis_tdata_o[1 + FRAME_FIELD_W +: TOTAL_W];
  assign beat_misses = m_axis_tdata_o[1 + FRAME_FIELD_W + TOTAL_W +: TOTAL_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_hits_q   <= '0;
      last_misses_q <= '0;
      in_beat_q     <= 1'b0;
    end else begin
      in_beat_q <= in_beat;
      if (out_beat) begin
        last_hits_q   <= beat_hits;
        last_misses_q <= beat_misses;
      end
    end
  end

  // Exactly one of the totals advances by one on every result beat
  a_totals_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> (beat_hits == last_hits_q + total_t'(beat_hit)) &&
                 (beat_misses == last_misses_q + total_t'(!beat_hit)))
    else $error("hit/miss totals did not step by one");

  // Once an accepted beat has passed the input register, a result beat is on the output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat_q |=> m_axis_tvalid_o)
    else $error("accepted access produced no result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat dropped or changed while stalled");

endmodule

bind lru_page_frame_lookup_unit lpfl_checker u_lpfl_checker (.*);

// ===== dv/lru_page_frame_lookup_unit_test.sv =====
module lru_page_frame_lookup_unit_test;
  import lpfl_pkg::*;

  localparam int unsigned LONG_STALL     = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned POOL_SIZE      = 12;

  // Output beat as laid out on m_axis_tdata_o
  typedef struct packed {
    logic [OUT_PAD_W-1:0]     pad;
    total_t                   miss_total;
    total_t                   hit_total;
    logic [FRAME_FIELD_W-1:0] frame;
    logic                     hit;
  } lookup_beat_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // [15:0] page_number
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;        // [0] hit, [3:1] frame,
                                                 // [35:4] hit_total,
                                                 // [67:36] miss_total, rest zero

  lru_page_frame_lookup_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow frame table
  page_t  tag_table [FRAMES];
  bit     frame_live[FRAMES];
  age_t   age_table [FRAMES];
  total_t hits_so_far;
  total_t misses_so_far;

  lookup_beat_t pending_lookups[$];
  lookup_beat_t seen_beat;
  lookup_beat_t want_beat;
  int unsigned  error_count;
  int unsigned  accesses_sent;
  bit           tx_gaps;
  bit           rx_gaps;
  bit           stall_request;
  page_t        page_pool[POOL_SIZE];

  function automatic lookup_beat_t predict_access(input page_t pg);
    int sel;
    lookup_beat_t r;
    sel = -1;
    r = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (frame_live[i] && tag_table[i] == pg) begin
        sel = i;
        break;
      end
    end
    if (sel >= 0) begin
      r.hit = 1'b1;
      hits_so_far++;
    end else begin
      misses_so_far++;
      for (int i = 0; i < FRAMES; i++) begin
        if (!frame_live[i]) begin
          sel = i;
          break;
        end
      end
      // every frame in use: evict the oldest, lowest index on ties
      if (sel < 0) begin
        sel = 0;
        for (int i = 1; i < FRAMES; i++) begin
          if (age_table[i] > age_table[sel]) sel = i;
        end
      end
      tag_table[sel]  = pg;
      frame_live[sel] = 1'b1;
    end
    for (int i = 0; i < FRAMES; i++) begin
      if (i == sel) age_table[i] = '0;
      else if (age_table[i] != '1) age_table[i] = age_table[i] + 1'b1;
    end
    r.frame      = sel[FRAME_FIELD_W-1:0];
    r.hit_total  = hits_so_far;
    r.miss_total = misses_so_far;
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  task automatic send_access(input page_t pg);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pg;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_lookups.push_back(predict_access(pg));
    accesses_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: random holds, or one long hold when asked
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      seen_beat = m_axis_tdata_o;
      if (pending_lookups.size() == 0) begin
        $error("result beat with nothing pending: %h", m_axis_tdata_o);
        error_count++;
      end else begin
        want_beat = pending_lookups.pop_front();
        if (seen_beat.hit !== want_beat.hit) begin
          $error("hit: expected %0d, got %0d", want_beat.hit, seen_beat.hit);
          error_count++;
        end
        if (seen_beat.frame !== want_beat.frame) begin
          $error("frame: expected %0d, got %0d", want_beat.frame, seen_beat.frame);
          error_count++;
        end
        if (seen_beat.hit_total !== want_beat.hit_total) begin
          $error("hit_total: expected %0d, got %0d", want_beat.hit_total,
                 seen_beat.hit_total);
          error_count++;
        end
        if (seen_beat.miss_total !== want_beat.miss_total) begin
          $error("miss_total: expected %0d, got %0d", want_beat.miss_total,
                 seen_beat.miss_total);
          error_count++;
        end
        if (seen_beat.pad !== want_beat.pad) begin
          $error("pad: expected %h, got %h", want_beat.pad, seen_beat.pad);
          error_count++;
        end
      end
    end
  end

  // Abort when no beat moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Empty table: extremes of the page field, hits, fill, then evictions
  task automatic test_cold_fill();
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'h5555);
    send_access(16'hAAAA);
    send_access(16'h0001);
    send_access(16'h8000);
    send_access(16'h00FF);
    send_access(16'hFF00);
    send_access(16'h5555);
    // table full: the misses among these evict the oldest frames
    send_access(16'h1234);
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'h1234);
    send_access(16'hAAAA);
    wait_for_results();
  endtask

  // Hold the output for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    stall_request = 1'b1;
    for (int n = 0; n < 24; n++) begin
      send_access((n % 3 == 0) ? tag_table[n % FRAMES] : page_t'($urandom));
    end
    wait_for_results();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    page_t pg;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = page_t'($urandom);
    for (int unsigned n = 0; n < count; n++) begin
      // stretches without any idling on either side
      tx_gaps = !(n >= 100 && n < 200);
      rx_gaps = !(n >= 150 && n < 250);
      if (n == count / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (pick < 55) pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 80) pg = tag_table[$urandom_range(0, FRAMES - 1)];
      else pg = page_t'($urandom);
      send_access(pg);
    end
    wait_for_results();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // Keep one frame hot back to back so the others age, then miss twice,
  // come back to the hot page and return to the first missed page
  task automatic test_hot_frame();
    page_t hot;
    hot = tag_table[3];
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    repeat (20) send_access(hot);
    send_access(16'hC000);
    send_access(16'hC001);
    send_access(hot);
    send_access(16'hC000);
    wait_for_results();
  endtask

  initial begin
    error_count   = 0;
    accesses_sent = 0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    stall_request = 1'b0;
    hits_so_far   = '0;
    misses_so_far = '0;
    for (int i = 0; i < FRAMES; i++) begin
      tag_table[i]  = '0;
      frame_live[i] = 1'b0;
      age_table[i]  = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cold_fill();
    test_backpressure();
    test_random_traffic(440);
    test_hot_frame();

    repeat (8) @(posedge clk_i);
    $display("Checked %0d page accesses (%0d hits, %0d misses) through fill, eviction,",
             accesses_sent, hits_so_far, misses_so_far);
    $display("long output stalls, idle gaps on both sides and a hot frame among aging ones.");
    if (error_count == 0 && pending_lookups.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
